/* hdl/sfx_pkg.sv */
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared types and constants for the SPI slave frame exchanger.
// ----------------------------------------------------------------------------
`default_nettype none

package sfx_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 16;

   localparam int OPCODE_W    = 2;
   localparam int BYTE_W      = 8;
   localparam int INDEX_W     = 4;
   localparam int CFG_LEN_W   = 5;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'hAC;
   localparam logic [BYTE_W-1:0] IDLE_BYTE  = 8'hFF;

   localparam logic [CFG_LEN_W-1:0] CFG_SEND_RESET = 5'd16;
   localparam logic [CFG_LEN_W-1:0] CFG_RECV_RESET = 5'd8;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_BYTE   = 2'd0,
      OP_LOAD   = 2'd1,
      OP_COMMIT = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEND_LEN = 1'b0,
      CSR_RECV_LEN = 1'b1
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [BYTE_W-1:0]   byte_value;
      logic [INDEX_W-1:0]  byte_index;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TX,
      ST_RX
   } back_state_type;

endpackage

`default_nettype wire

/* hdl/sfx_ram.sv */
// ----------------------------------------------------------------------------
// sfx_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/sfx_front.sv */
// ----------------------------------------------------------------------------
// sfx_front
// Accepts request transactions, drops unused opcodes, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sfx_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic [sfx_pkg::BYTE_W-1:0]   req_byte_value,
   input  wire logic [sfx_pkg::INDEX_W-1:0]  req_byte_index,
   output logic                              q_valid,
   output sfx_pkg::cmd_type                  q_cmd,
   input  wire logic                         q_pop
);

   import sfx_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              full;
   logic              known_op;
   logic              push;
   logic              pop;
   cmd_type           new_cmd;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign req_stall = full;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      case (req_opcode)
         OP_BYTE, OP_LOAD, OP_COMMIT: known_op = 1'b1;
         default:                     known_op = 1'b0;
      endcase
   end

   assign new_cmd.opcode     = opcode_type'(req_opcode);
   assign new_cmd.byte_value = req_byte_value;
   assign new_cmd.byte_index = req_byte_index;

   assign push = req_valid && !full && known_op;
   assign pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/sfx_back.sv */
// ----------------------------------------------------------------------------
// sfx_back
// Executes queued commands: send banks, receive store, frame sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module sfx_back #(
   parameter int MAX_FRAME_BYTES = sfx_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire sfx_pkg::cmd_type              q_cmd,
   output logic                               q_pop,
   input  wire logic [sfx_pkg::CFG_LEN_W-1:0] cfg_send_len,
   input  wire logic [sfx_pkg::CFG_LEN_W-1:0] cfg_recv_len,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_result_kind,
   output logic [sfx_pkg::BYTE_W-1:0]         rsp_result_byte,
   output logic [sfx_pkg::INDEX_W-1:0]        rsp_result_index,
   output logic                               rsp_frame_done,
   output logic                               rsp_last_of_run
);

   import sfx_pkg::*;

   localparam int PW         = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
   localparam int CW         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int SAW        = PW + 1;
   localparam int SEND_DEPTH = 2 ** SAW;

   back_state_type      state_ff, state_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic                active_ff, active_in;
   logic                pending_ff, pending_in;
   logic [SEND_DEPTH-1:0]      send_vld_ff, send_vld_in;
   logic [MAX_FRAME_BYTES-1:0] rx_vld_ff, rx_vld_in;
   logic [PW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       nr_ff, nr_in;
   logic                idle_ff, idle_in;
   logic                tx_zero_ff, tx_zero_in;
   logic                end_ff, end_in;
   logic                tx_vld_ff, tx_vld_in;
   logic                rx_rd_vld_ff, rx_rd_vld_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                kind_ff, kind_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic                done_ff, done_in;
   logic                last_ff, last_in;

   logic [CW-1:0]       ns, nr;
   logic [CW-1:0]       pos_w, pos_next;
   logic                out_free;
   logic                load_ok;

   logic                send_we, send_re;
   logic [SAW-1:0]      send_waddr, send_raddr;
   logic [BYTE_W-1:0]   send_rdata;
   logic                rx_we, rx_re;
   logic [PW-1:0]       rx_waddr, rx_raddr;
   logic [BYTE_W-1:0]   rx_rdata;

   sfx_ram #(.WIDTH(BYTE_W), .DEPTH(SEND_DEPTH), .AW(SAW)) u_send_ram (
      .clock   (clock),
      .wr_en   (send_we),
      .wr_addr (send_waddr),
      .wr_data (q_cmd.byte_value),
      .rd_en   (send_re),
      .rd_addr (send_raddr),
      .rd_data (send_rdata)
   );

   sfx_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_FRAME_BYTES), .AW(PW)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_waddr),
      .wr_data (q_cmd.byte_value),
      .rd_en   (rx_re),
      .rd_addr (rx_raddr),
      .rd_data (rx_rdata)
   );

   // effective lengths: send clamped to 1..max, receive saturated at send
   always_comb begin
      if (cfg_send_len == '0) begin
         ns = CW'(1);
      end else if (7'(cfg_send_len) > 7'(MAX_FRAME_BYTES)) begin
         ns = CW'(MAX_FRAME_BYTES);
      end else begin
         ns = CW'(cfg_send_len);
      end
      nr = (7'(cfg_recv_len) > 7'(ns)) ? ns : CW'(cfg_recv_len);
   end

   assign pos_w    = CW'(pos_ff);
   assign pos_next = pos_w + CW'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_ok  = 7'(q_cmd.byte_index) < 7'(MAX_FRAME_BYTES);

   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign send_raddr = {active_ff, pos_ff};
   assign send_waddr = {~active_ff, PW'(q_cmd.byte_index)};
   assign rx_waddr   = pos_ff - PW'(1);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      send_vld_in  = send_vld_ff;
      rx_vld_in    = rx_vld_ff;
      cnt_in       = cnt_ff;
      nr_in        = nr_ff;
      idle_in      = idle_ff;
      tx_zero_in   = tx_zero_ff;
      end_in       = end_ff;
      tx_vld_in    = tx_vld_ff;
      rx_rd_vld_in = rx_rd_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      index_in     = index_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      send_we      = 1'b0;
      send_re      = 1'b0;
      rx_we        = 1'b0;
      rx_re        = 1'b0;
      rx_raddr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.opcode)
                  OP_LOAD: begin
                     pending_in = 1'b0;
                     if (load_ok) begin
                        send_we                 = 1'b1;
                        send_vld_in[send_waddr] = 1'b1;
                     end
                  end
                  OP_COMMIT: begin
                     pending_in = 1'b1;
                  end
                  OP_BYTE: begin
                     state_in = ST_TX;
                     nr_in    = nr;
                     if (pos_ff == '0 && q_cmd.byte_value != START_BYTE) begin
                        idle_in = 1'b1;
                        end_in  = 1'b0;
                     end else begin
                        idle_in    = 1'b0;
                        send_re    = 1'b1;
                        tx_vld_in  = send_vld_ff[send_raddr];
                        tx_zero_in = pos_w >= ns;
                        if (pos_ff != '0 && pos_w <= nr) begin
                           rx_we               = 1'b1;
                           rx_vld_in[rx_waddr] = 1'b1;
                        end
                        if (pos_next >= ns) begin
                           end_in = 1'b1;
                           pos_in = '0;
                           if (pending_ff) begin
                              active_in  = ~active_ff;
                              pending_in = 1'b0;
                           end
                        end else begin
                           end_in = 1'b0;
                           pos_in = PW'(pos_next);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_TX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = 1'b0;
               index_in     = '0;
               done_in      = end_ff;
               if (idle_ff) begin
                  byte_in = IDLE_BYTE;
               end else if (tx_zero_ff || !tx_vld_ff) begin
                  byte_in = '0;
               end else begin
                  byte_in = send_rdata;
               end
               if (end_ff && nr_ff != '0) begin
                  last_in      = 1'b0;
                  state_in     = ST_RX;
                  cnt_in       = '0;
                  rx_re        = 1'b1;
                  rx_raddr     = '0;
                  rx_rd_vld_in = rx_vld_ff[0];
               end else begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_RX: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = 1'b1;
               byte_in      = rx_rd_vld_ff ? rx_rdata : '0;
               index_in     = INDEX_W'(cnt_ff);
               done_in      = 1'b0;
               if (CW'(cnt_ff) + CW'(1) == nr_ff) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  last_in      = 1'b0;
                  cnt_in       = cnt_ff + PW'(1);
                  rx_re        = 1'b1;
                  rx_raddr     = cnt_ff + PW'(1);
                  rx_rd_vld_in = rx_vld_ff[rx_raddr];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         active_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         send_vld_ff  <= '0;
         rx_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         send_vld_ff  <= send_vld_in;
         rx_vld_ff    <= rx_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      nr_ff        <= nr_in;
      idle_ff      <= idle_in;
      tx_zero_ff   <= tx_zero_in;
      end_ff       <= end_in;
      tx_vld_ff    <= tx_vld_in;
      rx_rd_vld_ff <= rx_rd_vld_in;
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      index_ff     <= index_in;
      done_ff      <= done_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_result_byte  = byte_ff;
   assign rsp_result_index = index_ff;
   assign rsp_frame_done   = done_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

`default_nettype wire

/* hdl/spi_slave_frame_exchanger.sv */
// ----------------------------------------------------------------------------
// spi_slave_frame_exchanger
// SPI slave frame engine: start-byte framing, double-buffered send bank,
// receive store reported at the end of each frame.
// ----------------------------------------------------------------------------
//
//   Port group | Handshake          | Carries
//   -----------+--------------------+-----------------------------------------
//   req_       | req_valid/req_stall| opcode, byte_value, byte_index
//   rsp_       | rsp_valid/rsp_stall| kind, byte, index, frame_done, last
//   csr_       | csr_valid/csr_ready| register index, write data (5 bits)
//
// Flow: the front queues up to two commands, so requests are taken while
// the back is busy. In the back a load or commit is handled in ST_IDLE; a
// finished byte in a frame reads the send RAM, then replies in ST_TX, then one
// reply per reported received byte follows in ST_RX at frame end.
// Reset is synchronous; valid bits clear the stores at once, no clearing pass.
// A held rsp_stall freezes the back; the queue fills, then req_stall rises.
//
`default_nettype none

module spi_slave_frame_exchanger #(
   parameter int MAX_FRAME_BYTES = sfx_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sfx_pkg::OPCODE_W-1:0]    req_opcode,
   input  wire logic [sfx_pkg::BYTE_W-1:0]      req_byte_value,
   input  wire logic [sfx_pkg::INDEX_W-1:0]     req_byte_index,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [sfx_pkg::BYTE_W-1:0]           rsp_result_byte,
   output logic [sfx_pkg::INDEX_W-1:0]          rsp_result_index,
   output logic                                 rsp_frame_done,
   output logic                                 rsp_last_of_run,
   // configuration write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sfx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfx_pkg::CFG_LEN_W-1:0]   csr_wdata
);

   import sfx_pkg::*;

   logic [CFG_LEN_W-1:0] send_len_ff, send_len_in;
   logic [CFG_LEN_W-1:0] recv_len_ff, recv_len_in;
   logic                 q_valid;
   logic                 q_pop;
   cmd_type              q_cmd;

   // registers always writable; user changes them only when idle, unchecked
   assign csr_ready = 1'b1;

   always_comb begin
      send_len_in = send_len_ff;
      recv_len_in = recv_len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SEND_LEN: send_len_in = csr_wdata;
            CSR_RECV_LEN: recv_len_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_len_ff <= CFG_SEND_RESET;
         recv_len_ff <= CFG_RECV_RESET;
      end else begin
         send_len_ff <= send_len_in;
         recv_len_ff <= recv_len_in;
      end
   end

   // front: take request transactions, drop unused opcodes, queue them
   sfx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_byte_value (req_byte_value),
      .req_byte_index (req_byte_index),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop)
   );

   // back: bank loads, commits, frame sequencing and the response register
   sfx_back #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .cfg_send_len     (send_len_ff),
      .cfg_recv_len     (recv_len_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_byte  (rsp_result_byte),
      .rsp_result_index (rsp_result_index),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire
